### sv/rc4sc_pkg.sv
// Shared types and constants for the RC4 stream cipher core.
`default_nettype none

package rc4sc_pkg;

	localparam int unsigned PERM_DEPTH = 256;
	localparam int unsigned BYTE_W     = 8;

	// Write request into the permutation memory
	typedef struct packed {
		logic              en;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} perm_wr_t;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_K_RD_I = 9'b000000010,
		ST_K_RD_J = 9'b000000100,
		ST_K_WR_I = 9'b000001000,
		ST_K_WR_J = 9'b000010000,
		ST_D_RD_Y = 9'b000100000,
		ST_D_WR_X = 9'b001000000,
		ST_D_WR_Y = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

endpackage

`default_nettype wire

### sv/rc4_stream_cipher_core.sv
// Top level of the RC4 stream cipher core: sequencer, key store and output register.
//
//  channel | dir | signals                         | request content
//  --------+-----+---------------------------------+----------------------------------
//  s_      | in  | tvalid tready tdata tuser tlast | byte_in, mode (tuser), key_last
//  m_      | out | tvalid tready tdata             | byte_out, one per data request
//
//  A data request runs ST_D_RD_Y, ST_D_WR_X, ST_D_WR_Y (three reads and two writes
//  on the single port pair of the permutation memory), then ST_EMIT on a stall.
//  A key request yields no result; the key_last one runs the schedule with s_tready
//  low: 256 swap steps through ST_K_RD_I, ST_K_RD_J, ST_K_WR_I and ST_K_WR_J.
//  After reset the permutation reads as identity at once; no clearing pass is needed.
//  A stalled result sits in the output register; the next request is taken meanwhile.
`default_nettype none

module rc4_stream_cipher_core #(
	parameter int unsigned KEY_MAX_BYTES = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] byte_in
	input  wire logic       s_tuser,   // [0] mode: 0 key byte, 1 data byte
	input  wire logic       s_tlast,   // key_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata    // [7:0] byte_out
);
	import rc4sc_pkg::*;

	localparam int unsigned CNT_W  = $clog2(KEY_MAX_BYTES + 1);
	localparam int unsigned KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

	state_t            state_q;
	logic [7:0]        x_q, y_q, i_q, j_q;
	logic [7:0]        a_q, b_q, byte_q, res_q;
	logic              fwd_x_q, fwd_y_q;
	logic [CNT_W-1:0]  key_count_q, klen_q;
	logic [KIDX_W-1:0] kpos_q;
	logic [7:0]        key_rd_q;
	logic [7:0]        key_mem [KEY_MAX_BYTES];
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;

	logic              in_acc, key_acc, data_acc, sched_start, out_free, key_full;
	logic [CNT_W-1:0]  count_next, kpos_inc;
	logic [7:0]        rdat, raddr, j_new, ks, tsel;
	logic              clr;
	perm_wr_t          wr;

	rc4sc_perm_ram u_perm (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.wr     (wr),
		.raddr  (raddr),
		.rdata  (rdat)
	);

	assign s_tready    = (state_q == ST_IDLE);
	assign in_acc      = s_tvalid && s_tready;
	assign key_acc     = in_acc && !s_tuser;
	assign data_acc    = in_acc && s_tuser;
	assign sched_start = key_acc && s_tlast;
	assign key_full    = (key_count_q == CNT_W'(KEY_MAX_BYTES));
	assign count_next  = key_full ? key_count_q : key_count_q + CNT_W'(1);
	assign kpos_inc    = CNT_W'(kpos_q) + CNT_W'(1);
	assign out_free    = !m_tvalid_q || m_tready;
	assign j_new       = j_q + rdat + key_rd_q;
	assign tsel        = a_q + rdat;
	assign ks          = fwd_y_q ? a_q : (fwd_x_q ? b_q : rdat);
	assign m_tvalid    = m_tvalid_q;
	assign m_tdata     = m_tdata_q;

	// Memory address and write selection per state
	always_comb begin
		raddr = x_q + 8'd1;
		wr    = '0;
		clr   = 1'b0;
		case (state_q)
			ST_IDLE:   clr   = sched_start;
			ST_K_RD_I: raddr = i_q;
			ST_K_RD_J: raddr = j_new;
			ST_K_WR_I: wr    = '{en: 1'b1, addr: i_q, data: rdat};
			ST_K_WR_J: wr    = '{en: 1'b1, addr: j_q, data: a_q};
			ST_D_RD_Y: raddr = y_q + rdat;
			ST_D_WR_X: begin
				wr    = '{en: 1'b1, addr: x_q, data: rdat};
				raddr = tsel;
			end
			ST_D_WR_Y: wr    = '{en: 1'b1, addr: y_q, data: a_q};
			ST_EMIT:   ;
			default:   ;
		endcase
	end

	// Sequencer, indices and key counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			key_count_q <= '0;
			klen_q      <= '0;
			kpos_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (key_acc) begin
						if (s_tlast) begin
							klen_q      <= count_next;
							key_count_q <= '0;
							kpos_q      <= '0;
							i_q         <= '0;
							j_q         <= '0;
							x_q         <= '0;
							y_q         <= '0;
							state_q     <= ST_K_RD_I;
						end else begin
							key_count_q <= count_next;
						end
					end else if (data_acc) begin
						x_q     <= x_q + 8'd1;
						state_q <= ST_D_RD_Y;
					end
				end
				ST_K_RD_I: state_q <= ST_K_RD_J;
				ST_K_RD_J: begin
					j_q     <= j_new;
					state_q <= ST_K_WR_I;
				end
				ST_K_WR_I: state_q <= ST_K_WR_J;
				ST_K_WR_J: begin
					i_q    <= i_q + 8'd1;
					kpos_q <= (kpos_inc == klen_q) ? '0 : kpos_inc[KIDX_W-1:0];
					state_q <= (i_q == 8'hFF) ? ST_IDLE : ST_K_RD_I;
				end
				ST_D_RD_Y: begin
					y_q     <= y_q + rdat;
					state_q <= ST_D_WR_X;
				end
				ST_D_WR_X: state_q <= ST_D_WR_Y;
				ST_D_WR_Y: state_q <= out_free ? ST_IDLE : ST_EMIT;
				ST_EMIT:   if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (((state_q == ST_D_WR_Y) || (state_q == ST_EMIT)) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Datapath registers and key store
	always_ff @(posedge clk) begin
		key_rd_q <= key_mem[kpos_q];
		if (key_acc && !key_full) begin
			key_mem[key_count_q[KIDX_W-1:0]] <= s_tdata;
		end
		if (data_acc) begin
			byte_q <= s_tdata;
		end
		case (state_q)
			ST_K_RD_J: a_q <= rdat;
			ST_D_RD_Y: a_q <= rdat;
			ST_D_WR_X: begin
				b_q     <= rdat;
				// keystream entry read now sees neither write of this swap yet
				fwd_y_q <= (tsel == y_q);
				fwd_x_q <= (tsel == x_q);
			end
			ST_D_WR_Y: begin
				res_q <= byte_q ^ ks;
				if (out_free) begin
					m_tdata_q <= byte_q ^ ks;
				end
			end
			ST_EMIT: if (out_free) m_tdata_q <= res_q;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### sv/rc4sc_perm_ram.sv
// Permutation memory: 256 x 8, one write and one registered read per cycle;
// entries without a valid bit read as their own address (identity).
`default_nettype none

module rc4sc_perm_ram (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clr,
	input  wire rc4sc_pkg::perm_wr_t wr,
	input  wire logic [7:0]         raddr,
	output logic [7:0]              rdata
);
	import rc4sc_pkg::*;

	logic [BYTE_W-1:0]     mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] vld_q;
	logic [BYTE_W-1:0]     rd_mem_q;
	logic [BYTE_W-1:0]     rd_addr_q;
	logic                  rd_vld_q;

	// Valid bits: cleared at reset and at the start of a key schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	// Storage and registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_mem_q  <= mem[raddr];
		rd_vld_q  <= vld_q[raddr];
		rd_addr_q <= raddr;
	end

	assign rdata = rd_vld_q ? rd_mem_q : rd_addr_q;

endmodule

`default_nettype wire

### sv/rc4sc_checker.sv
// Port-level checks for the RC4 stream cipher core, bound to the top level.
`default_nettype none

module rc4sc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       s_tuser,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// A key request never produces a result
	a_key_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !$rose(m_tvalid))
		else $error("result after key request");

	// Engine is busy right after a data request
	a_data_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("request taken while data byte in progress");

	// Key schedule holds off requests
	a_sched_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser && s_tlast |=> !s_tready ##1 !s_tready)
		else $error("request taken during key schedule");

endmodule

bind rc4_stream_cipher_core rc4sc_checker u_rc4sc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the RC4 stream cipher core: key and data requests checked by a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned KEY_MAX   = 256;
	localparam int unsigned N_ITEMS   = 1400;
	localparam int unsigned LIMIT     = 3_000_000;
	localparam int unsigned HOLD_LEN  = 400;
	localparam int unsigned HOLD_AT   = 150;
	localparam int unsigned TAIL_WAIT = 1100;
	localparam bit          MODE_KEY  = 1'b0;
	localparam bit          MODE_DATA = 1'b1;

	// Receiver stall patterns
	typedef enum int unsigned {
		RX_ALWAYS,
		RX_HALF,
		RX_SPARSE,
		RX_MOSTLY
	} rx_pattern_t;

	// Predicts the cipher state and holds the output bytes still due
	class arcfour_scoreboard;
		logic [7:0]  perm [256];
		logic [7:0]  key_bytes [256];
		int unsigned key_len;
		logic [7:0]  idx_x;
		logic [7:0]  idx_y;
		logic [7:0]  expected_bytes [$];
		int unsigned n_mismatch;

		function new();
			foreach (perm[i]) perm[i] = 8'(i);
			key_len    = 0;
			idx_x      = 8'd0;
			idx_y      = 8'd0;
			n_mismatch = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			n_mismatch++;
		endtask

		// Identity, then 256 swap steps over the stored key bytes
		function void run_key_schedule();
			int unsigned len;
			int unsigned kpos;
			logic [7:0]  j;
			logic [7:0]  a;
			len  = (key_len == 0) ? 1 : key_len;
			kpos = 0;
			j    = 8'd0;
			foreach (perm[i]) perm[i] = 8'(i);
			for (int i = 0; i < 256; i++) begin
				a       = perm[i];
				j       = j + a + key_bytes[kpos];
				perm[i] = perm[j];
				perm[j] = a;
				kpos    = (kpos + 1 >= len) ? 0 : kpos + 1;
			end
			idx_x   = 8'd0;
			idx_y   = 8'd0;
			key_len = 0;
		endfunction

		function void note_request(input bit mode, input logic [7:0] b, input bit last);
			logic [7:0] a;
			logic [7:0] c;
			logic [7:0] t;
			if (mode == MODE_KEY) begin
				// bytes past the key store are dropped; last still schedules
				if (key_len < KEY_MAX) begin
					key_bytes[key_len] = b;
					key_len++;
				end
				if (last) run_key_schedule();
			end else begin
				idx_x       = idx_x + 8'd1;
				a           = perm[idx_x];
				idx_y       = idx_y + a;
				c           = perm[idx_y];
				perm[idx_x] = c;
				perm[idx_y] = a;
				t           = a + c;
				expected_bytes.push_back(b ^ perm[t]);
			end
		endfunction

		task check_byte(input logic [7:0] got);
			logic [7:0] want;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte_out %02h", got));
			end else begin
				want = expected_bytes.pop_front();
				if (got !== want)
					report_mismatch($sformatf("byte_out %02h, expected %02h", got, want));
			end
		endtask
	endclass

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'd0;
	logic       s_tuser  = 1'b0;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	arcfour_scoreboard scb = new();

	int unsigned burst_left  = 0;
	int unsigned items_done  = 0;
	int unsigned cycle_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rc4_stream_cipher_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one request, wait for it to be taken, then pace the next burst
	task automatic send_req(input bit mode, input logic [7:0] b, input bit last);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (mode == MODE_DATA || scb.key_len < KEY_MAX) items_done++;
		scb.note_request(mode, b, last);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_key(input int unsigned len, input bit finish);
		for (int unsigned k = 0; k < len; k++)
			send_req(MODE_KEY, 8'($urandom), finish && (k == len - 1));
	endtask

	// key_last is random on data requests; the block must ignore it
	task automatic send_data_run(input int unsigned n);
		repeat (n) send_req(MODE_DATA, 8'($urandom), 1'($urandom));
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (scb.expected_bytes.size() != 0);
	endtask

	// Result side: stall patterns, plus one long hold-off
	initial begin : result_sink
		int unsigned phase_left;
		int unsigned n_seen;
		bit          held;
		bit          rdy;
		rx_pattern_t pattern;
		phase_left = 0;
		n_seen     = 0;
		held       = 1'b0;
		pattern    = RX_ALWAYS;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				scb.check_byte(m_tdata);
				n_seen++;
			end
			if (!held && n_seen >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end
			if (phase_left == 0) begin
				pattern    = rx_pattern_t'($urandom_range(0, 3));
				phase_left = $urandom_range(20, 200);
			end
			phase_left--;
			case (pattern)
				RX_ALWAYS: rdy = 1'b1;
				RX_HALF:   rdy = 1'($urandom);
				RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
				default:   rdy = ($urandom_range(0, 9) != 0);
			endcase
			m_tready <= rdy;
		end
	end

	initial begin : stimulus
		int unsigned n_seq;
		int unsigned klen;
		int unsigned pick;
		bit          paused;
		n_seq  = 0;
		paused = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// data before any key runs on the identity permutation
		send_req(MODE_DATA, 8'h00, 1'b0);
		send_req(MODE_DATA, 8'hFF, 1'b1);
		send_req(MODE_DATA, 8'h5A, 1'b0);
		// one-byte keys at both extremes
		send_req(MODE_KEY, 8'h00, 1'b1);
		send_req(MODE_DATA, 8'h00, 1'b0);
		send_req(MODE_DATA, 8'hFF, 1'b0);
		send_req(MODE_KEY, 8'hFF, 1'b1);
		send_req(MODE_DATA, 8'hA5, 1'b0);
		// short ASCII key with plaintext
		send_req(MODE_KEY, 8'h4B, 1'b0);
		send_req(MODE_KEY, 8'h65, 1'b0);
		send_req(MODE_KEY, 8'h79, 1'b1);
		send_req(MODE_DATA, 8'h50, 1'b0);
		send_req(MODE_DATA, 8'h6C, 1'b0);
		send_req(MODE_DATA, 8'h61, 1'b0);
		send_req(MODE_DATA, 8'h69, 1'b0);
		// data while key bytes are pending, then finish the key
		send_req(MODE_KEY, 8'h01, 1'b0);
		send_req(MODE_KEY, 8'h80, 1'b0);
		send_req(MODE_DATA, 8'h3C, 1'b0);
		send_req(MODE_DATA, 8'hC3, 1'b1);
		send_req(MODE_KEY, 8'h7E, 1'b1);
		send_req(MODE_DATA, 8'h00, 1'b0);
		send_req(MODE_DATA, 8'hFF, 1'b0);
		wait_for_results();

		// random sequences; the first two fill the key store and overflow it
		items_done = 0;
		while (items_done < N_ITEMS) begin
			if (n_seq == 0)
				klen = KEY_MAX;
			else if (n_seq == 1)
				klen = $urandom_range(KEY_MAX + 1, KEY_MAX + 40);
			else
				klen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
				                                   : $urandom_range(1, 16);
			pick = $urandom_range(0, 99);
			if (n_seq < 2 || pick < 70) begin
				send_key(klen, 1'b1);
				send_data_run($urandom_range(4, 40));
			end else if (pick < 80) begin
				// key left pending across data
				send_key($urandom_range(1, 6), 1'b0);
				send_data_run($urandom_range(1, 10));
			end else if (pick < 90) begin
				send_data_run($urandom_range(1, 20));
			end else begin
				send_key($urandom_range(1, 3), 1'b1);
			end
			n_seq++;
			if (!paused && items_done >= N_ITEMS / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
		end

		wait_for_results();
		repeat (TAIL_WAIT) @(posedge clk);
		if (scb.n_mismatch == 0 && scb.expected_bytes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
